// ===== hw/rtl/wnf_pkg.sv =====
// Shared types and constants for the wide-in narrow-out FIFO.
package wnf_pkg;

    localparam int DEPTH_DEFAULT              = 64;
    localparam int RATIO_DEFAULT              = 4;
    localparam int ELEMENTS_PER_CHUNK_DEFAULT = 2;
    localparam int ELEMENT_BITS_DEFAULT       = 8;

    localparam int WORD_BITS      = 64;
    localparam int CHUNK_OUT_BITS = 16;
    localparam int LEVEL_BITS     = 7;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [LEVEL_BITS-1:0] ALMOST_EMPTY_RESET = 7'd4;
    localparam logic [LEVEL_BITS-1:0] ALMOST_FULL_RESET  = 7'd64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ALMOST_EMPTY = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALMOST_FULL  = 1'd1;

    typedef struct packed {
        logic                 read_enable;
        logic                 write_enable;
        logic [WORD_BITS-1:0] write_word;
    } in_t;

    typedef struct packed {
        logic [CHUNK_OUT_BITS-1:0] read_chunk;
        logic                      is_empty;
        logic                      is_almost_empty;
        logic                      is_full;
        logic                      is_almost_full;
        logic                      overflow;
        logic                      underflow;
    } out_t;

endpackage

// ===== hw/rtl/wnf_store.sv =====
// Word memory of the FIFO with registered read and chunk selection.
module wnf_store
    import wnf_pkg::*;
#(
    parameter int WORDS      = (DEPTH_DEFAULT + 2 * RATIO_DEFAULT - 2) / RATIO_DEFAULT,
    parameter int RATIO      = RATIO_DEFAULT,
    parameter int CHUNK_BITS = ELEMENTS_PER_CHUNK_DEFAULT * ELEMENT_BITS_DEFAULT
)
(
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [$clog2(WORDS)-1:0]                     waddr,
    input  logic [WORD_BITS-1:0]                         wdata,
    input  logic [$clog2(WORDS)-1:0]                     raddr,
    input  logic [((RATIO > 1) ? $clog2(RATIO) : 1)-1:0] offset,
    output logic [CHUNK_OUT_BITS-1:0]                    chunk
);

    localparam int OFF_W  = (RATIO > 1) ? $clog2(RATIO) : 1;
    localparam int CAND_N = 1 << OFF_W;
    localparam logic [CHUNK_OUT_BITS-1:0] OUT_MASK =
        (CHUNK_BITS >= CHUNK_OUT_BITS) ? {CHUNK_OUT_BITS{1'b1}}
                                       : CHUNK_OUT_BITS'((1 << CHUNK_BITS) - 1);

    logic [WORD_BITS-1:0]      mem [WORDS];
    logic [WORD_BITS-1:0]      rdata_reg;
    logic [CHUNK_OUT_BITS-1:0] cand [CAND_N];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // chunks lying above the top of the word read as zero
    always_comb
    begin
        logic [WORD_BITS-1:0] shifted;
        for (int k = 0; k < CAND_N; k++)
        begin
            if (k < RATIO && k * CHUNK_BITS < WORD_BITS)
            begin
                shifted = rdata_reg >> (k * CHUNK_BITS);
            end
            else
            begin
                shifted = '0;
            end
            cand[k] = shifted[CHUNK_OUT_BITS-1:0] & OUT_MASK;
        end
    end

    assign chunk = cand[offset];

endmodule

// ===== hw/rtl/wide_in_narrow_out_fifo_top.sv =====
// Wide-in narrow-out FIFO: wide words pushed, narrow chunks popped, one status transaction each.
//
// Every input transaction carries an optional pop and an optional push of one
// wide word; the pop is applied first, then the word is queued as RATIO chunks,
// chunk 0 from the low bits first. Each transaction yields one result with the
// head chunk (zero when empty) and the level and error flags after the update.
// A push without room for a whole word is dropped and flags overflow; a pop on an
// empty queue is ignored and flags underflow. Chunks are kept whole-word in one
// memory of (DEPTH + 2*RATIO - 2) / RATIO rows with a registered read.
// The result register is loaded after the update and write at the accepting edge,
// then the memory read, then chunk selection; the next transaction is accepted
// once the result register is loaded, which out_stall can hold off.
// Thresholds are written through cfg_we/cfg_index/cfg_data while the block is idle;
// the user must keep to this, the block itself does not enforce it.
module wide_in_narrow_out_fifo_top
    import wnf_pkg::*;
#(
    parameter int DEPTH              = DEPTH_DEFAULT,
    parameter int RATIO              = RATIO_DEFAULT,
    parameter int ELEMENTS_PER_CHUNK = ELEMENTS_PER_CHUNK_DEFAULT,
    parameter int ELEMENT_BITS       = ELEMENT_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_t                       in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_t                      out_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LEVEL_BITS-1:0]     cfg_data
);

    localparam int CHUNK_BITS = ELEMENTS_PER_CHUNK * ELEMENT_BITS;
    localparam int WORDS      = (DEPTH + 2 * RATIO - 2) / RATIO;
    localparam int WAW        = $clog2(WORDS);
    localparam int OFF_W      = (RATIO > 1) ? $clog2(RATIO) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = ((CNT_W > LEVEL_BITS) ? CNT_W : LEVEL_BITS) + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [WAW-1:0]          head_word_reg, head_word_next;
    logic [OFF_W-1:0]        head_off_reg, head_off_next;
    logic [WAW-1:0]          tail_word_reg, tail_word_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LEVEL_BITS-1:0]   almost_empty_reg, almost_full_reg;
    logic                    overflow_reg, overflow_next;
    logic                    underflow_reg, underflow_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_data_reg, out_data_next;

    logic                    accept;
    logic                    do_pop, do_push;
    logic [CNT_W-1:0]        count_mid;
    logic                    load_out;
    logic [SUM_W-1:0]        count_wide;
    logic [CHUNK_OUT_BITS-1:0] chunk;

    wnf_store #(
        .WORDS      (WORDS),
        .RATIO      (RATIO),
        .CHUNK_BITS (CHUNK_BITS)
    ) u_store (
        .clk    (clk),
        .we     (do_push),
        .waddr  (tail_word_reg),
        .wdata  (in_data.write_word),
        .raddr  (head_word_reg),
        .offset (head_off_reg),
        .chunk  (chunk)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // queue update for the accepted transaction: pop first, then push
    always_comb
    begin
        do_pop    = accept && in_data.read_enable && (count_reg != '0);
        count_mid = count_reg - CNT_W'(do_pop);
        do_push   = accept && in_data.write_enable &&
                    (SUM_W'(count_mid) + SUM_W'(RATIO) <= SUM_W'(DEPTH));

        head_word_next = head_word_reg;
        head_off_next  = head_off_reg;
        if (do_pop)
        begin
            if (head_off_reg == OFF_W'(RATIO - 1))
            begin
                head_off_next  = '0;
                head_word_next = (head_word_reg == WAW'(WORDS - 1)) ? '0
                                                                    : head_word_reg + 1'b1;
            end
            else
            begin
                head_off_next = head_off_reg + 1'b1;
            end
        end

        tail_word_next = tail_word_reg;
        count_next     = count_mid;
        if (do_push)
        begin
            tail_word_next = (tail_word_reg == WAW'(WORDS - 1)) ? '0 : tail_word_reg + 1'b1;
            count_next     = count_mid + CNT_W'(RATIO);
        end

        overflow_next  = overflow_reg;
        underflow_next = underflow_reg;
        if (accept)
        begin
            overflow_next  = in_data.write_enable && !do_push;
            underflow_next = in_data.read_enable && (count_reg == '0);
        end
    end

    // result assembly and sequencing
    always_comb
    begin
        count_wide = SUM_W'(count_reg);
        load_out   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

        out_data_next                 = out_data_reg;
        out_data_next.read_chunk      = (count_reg == '0) ? '0 : chunk;
        out_data_next.is_empty        = (count_reg == '0);
        out_data_next.is_almost_empty = (count_wide <= SUM_W'(almost_empty_reg));
        out_data_next.is_full         = (count_wide + SUM_W'(RATIO) > SUM_W'(DEPTH));
        out_data_next.is_almost_full  = (count_wide + SUM_W'(RATIO) > SUM_W'(almost_full_reg));
        out_data_next.overflow        = overflow_reg;
        out_data_next.underflow       = underflow_reg;

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_word_reg    <= '0;
            head_off_reg     <= '0;
            tail_word_reg    <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            underflow_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            almost_empty_reg <= ALMOST_EMPTY_RESET;
            almost_full_reg  <= ALMOST_FULL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_word_reg <= head_word_next;
            head_off_reg  <= head_off_next;
            tail_word_reg <= tail_word_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            underflow_reg <= underflow_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALMOST_EMPTY: almost_empty_reg <= cfg_data;
                    REG_ALMOST_FULL:  almost_full_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== sim/wide_in_narrow_out_fifo_top_tb.sv =====
// Testbench for the wide-in narrow-out FIFO: predicts every status transaction and checks it.
module wide_in_narrow_out_fifo_top_tb;
    import wnf_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int RATIO       = RATIO_DEFAULT;
    localparam int CHUNK_BITS  = ELEMENTS_PER_CHUNK_DEFAULT * ELEMENT_BITS_DEFAULT;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int CYCLE_LIMIT = 400000;

    // Predicts the queue of chunks and the flags; holds the expected status transactions.
    class fifo_scoreboard;
        logic [CHUNK_OUT_BITS-1:0] chunk_mem [DEPTH];
        int unsigned               rd_ptr;
        int unsigned               wr_ptr;
        int unsigned               fill;
        int unsigned               empty_level;
        int unsigned               full_level;
        out_t                      status_q [$];
        int                        errors;
        int                        checked;
        int                        n_full;
        int                        n_overflow;
        int                        n_underflow;
        int                        n_empty;

        function new();
            rd_ptr      = 0;
            wr_ptr      = 0;
            fill        = 0;
            empty_level = ALMOST_EMPTY_RESET;
            full_level  = ALMOST_FULL_RESET;
            errors      = 0;
            checked     = 0;
            n_full      = 0;
            n_overflow  = 0;
            n_underflow = 0;
            n_empty     = 0;
        endfunction

        function void set_level(logic [CFG_INDEX_BITS-1:0] idx, logic [LEVEL_BITS-1:0] val);
            if (idx == REG_ALMOST_EMPTY)
                empty_level = val;
            else if (idx == REG_ALMOST_FULL)
                full_level = val;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void note_input(in_t t);
            out_t        e;
            logic [63:0] shifted;
            e = '0;
            if (t.read_enable)
            begin
                if (fill == 0)
                begin
                    e.underflow = 1'b1;
                end
                else
                begin
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                end
            end
            if (t.write_enable)
            begin
                if (fill + RATIO > DEPTH)
                begin
                    e.overflow = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < RATIO; k++)
                    begin
                        // chunks above the word read as zero
                        if (k * CHUNK_BITS >= WORD_BITS)
                            shifted = '0;
                        else
                            shifted = t.write_word >> (k * CHUNK_BITS);
                        chunk_mem[wr_ptr] = shifted[CHUNK_OUT_BITS-1:0];
                        wr_ptr = (wr_ptr + 1) % DEPTH;
                    end
                    fill += RATIO;
                end
            end
            e.read_chunk      = (fill != 0) ? chunk_mem[rd_ptr] : '0;
            e.is_empty        = (fill == 0);
            e.is_almost_empty = (fill <= empty_level);
            e.is_full         = (fill + RATIO > DEPTH);
            e.is_almost_full  = (fill + RATIO > full_level);
            n_full      += e.is_full;
            n_overflow  += e.overflow;
            n_underflow += e.underflow;
            n_empty     += e.is_empty;
            status_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 checked, name, got, want));
        endtask

        task check_result(out_t got);
            out_t want;
            if (status_q.size() == 0)
            begin
                report($sformatf("status transaction with nothing pending: 0x%0h", got));
                return;
            end
            want = status_q.pop_front();
            compare_field("read_chunk", got.read_chunk, want.read_chunk);
            compare_field("is_empty", got.is_empty, want.is_empty);
            compare_field("is_almost_empty", got.is_almost_empty, want.is_almost_empty);
            compare_field("is_full", got.is_full, want.is_full);
            compare_field("is_almost_full", got.is_almost_full, want.is_almost_full);
            compare_field("overflow", got.overflow, want.overflow);
            compare_field("underflow", got.underflow, want.underflow);
            checked++;
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    in_t                       in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_t                      out_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [LEVEL_BITS-1:0]     cfg_data;

    fifo_scoreboard sb = new();
    int             cycles = 0;
    int             sent = 0;
    bit             send_calm = 1'b0;
    bit             recv_calm = 1'b0;

    wide_in_narrow_out_fifo_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(in_data);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Receiver: stall a random number of cycles before each result, calm stretches included.
    initial
    begin : receiver
        int wait_cycles;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 59) == 0)
                recv_calm = ~recv_calm;
            wait_cycles = recv_calm ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    task automatic send_item(input in_t t);
        int gap;
        if ($urandom_range(0, 59) == 0)
            send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Holds off the sender until every expected status transaction has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_we high so writes can follow back to back; the caller drops it.
    task automatic write_level(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [LEVEL_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_level(idx, val);
    endtask

    function automatic in_t make_item(bit rd, bit wr, logic [WORD_BITS-1:0] w);
        in_t t;
        t.read_enable  = rd;
        t.write_enable = wr;
        t.write_word   = w;
        return t;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin : stimulus
        bit filling;
        bit rd;
        bit wr;
        int ae;
        int af;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ALMOST_EMPTY;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pop on empty, pop+push on empty, fill to full, overflow, pop+push at the edge
        send_item(make_item(1'b1, 1'b0, '0));
        send_item(make_item(1'b1, 1'b1, '1));
        send_item(make_item(1'b0, 1'b0, '1));
        send_item(make_item(1'b0, 1'b1, '0));
        send_item(make_item(1'b0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
        send_item(make_item(1'b0, 1'b1, 64'h5555_5555_5555_5555));
        repeat (12) send_item(make_item(1'b0, 1'b1, rand_word()));
        send_item(make_item(1'b0, 1'b1, '1));
        send_item(make_item(1'b1, 1'b1, '1));
        send_item(make_item(1'b1, 1'b0, '0));
        send_item(make_item(1'b1, 1'b0, '0));
        send_item(make_item(1'b1, 1'b1, 64'h0123_4567_89AB_CDEF));
        send_item(make_item(1'b1, 1'b0, '0));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (5) @(posedge clk);
            case (p)
                0:
                begin
                    ae = 0;
                    af = RATIO;
                end
                1:
                begin
                    ae = 64;
                    af = 64;
                end
                2:
                begin
                    ae = ALMOST_EMPTY_RESET;
                    af = ALMOST_FULL_RESET;
                end
                default:
                begin
                    ae = $urandom_range(0, 64);
                    af = $urandom_range(RATIO, 64);
                end
            endcase
            write_level(REG_ALMOST_EMPTY, LEVEL_BITS'(ae));
            write_level(REG_ALMOST_FULL, LEVEL_BITS'(af));
            cfg_we <= 1'b0;
            filling = 1'($urandom_range(0, 1));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and draining runs to reach both ends of the queue
                if ($urandom_range(0, 39) == 0)
                    filling = ~filling;
                if (filling)
                begin
                    wr = ($urandom_range(0, 99) < 75);
                    rd = ($urandom_range(0, 99) < 35);
                end
                else
                begin
                    wr = ($urandom_range(0, 99) < 25);
                    rd = ($urandom_range(0, 99) < 75);
                end
                if (i == PHASE_ITEMS / 2)
                    wait_drained();
                send_item(make_item(rd, wr, rand_word()));
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d status transactions never arrived", sb.pending()));
        $display("covered %0d transactions across %0d threshold settings, %0d results checked",
                 sent, PHASES + 1, sb.checked);
        $display("queue empty %0d times, full %0d times, overflow %0d, underflow %0d",
                 sb.n_empty, sb.n_full, sb.n_overflow, sb.n_underflow);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
